### hw/rtl/pspcr_pkg.sv
package pspcr_pkg;

    localparam int NOW_W     = 32;
    localparam int ADDR_W    = 7;
    localparam int CHAN_W    = 2;
    localparam int OPT_W     = 8;
    localparam int RAW_W     = 16;
    localparam int VOLT_W    = 15;
    localparam int READING_W = 31;
    localparam int FAIL_W    = 3;
    localparam int AGE_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 88;
    localparam int M_DATA_W  = 56;
    localparam int CONF_W    = 16;

    localparam logic [CONF_W-1:0] CONF_WORD_32V = 16'h399F;
    localparam logic [CONF_W-1:0] CONF_WORD_16V = 16'h019F;
    localparam logic [OPT_W-1:0]  OPT_RANGE_32V = 8'd1;
    localparam logic [FAIL_W-1:0] FAIL_SAT      = 3'd7;

    localparam logic [CHAN_W-1:0] CHAN_VOLT    = 2'd0;
    localparam logic [CHAN_W-1:0] CHAN_CURRENT = 2'd1;
    localparam logic [CHAN_W-1:0] CHAN_POWER   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_AGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        MODE_UNINIT = 2'd0,
        MODE_READY  = 2'd1,
        MODE_ERROR  = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                    mode;
        logic [FAIL_W-1:0]        fail_count;
        logic [NOW_W-1:0]         last_good_ms;
        logic                     cache_valid;
        logic [VOLT_W-1:0]        volt_mv;
        logic signed [RAW_W-1:0]  shunt;
        logic [NOW_W-1:0]         cache_time_ms;
    } slot_state_t;

    localparam slot_state_t SLOT_RESET = '0;

    typedef struct packed {
        logic [NOW_W-1:0]  now_ms;
        logic [CHAN_W-1:0] channel;
        logic [OPT_W-1:0]  range_option;
        logic              init_write_ok;
        logic              bus_read_ok;
        logic [RAW_W-1:0]  raw_bus_word;
        logic [RAW_W-1:0]  raw_shunt_word;
    } req_t;

    typedef struct packed {
        logic [AGE_W-1:0]  cache_age_ms;
        logic [AGE_W-1:0]  retry_ms;
        logic [FAIL_W-1:0] error_limit;
    } cfg_t;

    typedef struct packed {
        logic                        did_bus_read;
        logic [CONF_W-1:0]           config_word;
        logic                        did_config_write;
        logic signed [READING_W-1:0] reading;
        logic                        value_ok;
    } result_t;

endpackage

### hw/rtl/power_sensor_poll_cache_retry.sv
// Poll manager for a bus and shunt power monitor, with a per-slot reading
// cache and error retry. Each request item on the s_ channel names a device
// address (the address modulo SLOTS selects a slot), the current time, the channel and
// the outcomes of any bus traffic. Each request gives exactly one result
// item on the m_ channel: a reading when one is valid, and flags telling
// which bus operation the request issued.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata. The user must write them only while no item is in flight;
// the block does not enforce this. An accepted item is registered and its
// slot state read from the slot memory; when the result register is free or
// the receiver takes its item, the result register is loaded and the slot
// is written back. The step is a slot read, update and write-back with one
// multiply. One item can be accepted every cycle while results are taken.
// A request that follows one to the same slot uses the forwarded state.
// Reset returns every slot to uninitialized with an empty cache and loads
// the register defaults. When the receiver stalls, the result register
// holds and s_tready drops once the request stage is also full.
module power_sensor_poll_cache_retry
    import pspcr_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // now_ms, device_address, range_option, init_write_ok, bus_read_ok,
    // raw_bus_word, raw_shunt_word, zero fill
    input  logic [S_DATA_W-1:0]  s_tdata,
    // channel
    input  logic [CHAN_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value_ok, reading, did_config_write, config_word, did_bus_read, zero fill
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_N = 2 ** ADDR_W;

    logic [SLOT_W-1:0] slot_lut [ADDR_N];

    generate
        for (genvar g = 0; g < ADDR_N; g++) begin : g_slot_lut
            localparam int SlotOf = g % SLOTS;
            assign slot_lut[g] = SlotOf[SLOT_W-1:0];
        end
    endgenerate

    cfg_t              cfg_reg;
    req_t              req_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              st_vld_reg;
    logic              m_tvalid_reg;
    result_t           m_res_reg;

    req_t              s_req;
    logic [SLOT_W-1:0] s_slot;
    logic              accept;
    logic              advance;
    logic              st_fire;
    slot_state_t       cur_state;
    slot_state_t       nxt_state;
    result_t           res;

    assign s_req.now_ms         = s_tdata[31:0];
    assign s_req.range_option   = s_tdata[46:39];
    assign s_req.init_write_ok  = s_tdata[47];
    assign s_req.bus_read_ok    = s_tdata[48];
    assign s_req.raw_bus_word   = s_tdata[64:49];
    assign s_req.raw_shunt_word = s_tdata[80:65];
    assign s_req.channel        = s_tuser;
    assign s_slot               = slot_lut[s_tdata[38:32]];

    assign advance  = !m_tvalid_reg || m_tready;
    assign st_fire  = st_vld_reg && advance;
    assign s_tready = !st_vld_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, m_res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cache_age_ms <= AGE_W'(100);
            cfg_reg.retry_ms     <= AGE_W'(2000);
            cfg_reg.error_limit  <= FAIL_W'(5);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CACHE_AGE: cfg_reg.cache_age_ms <= cfg_wdata[AGE_W-1:0];
                CFG_RETRY:     cfg_reg.retry_ms     <= cfg_wdata[AGE_W-1:0];
                CFG_ERR_LIMIT: cfg_reg.error_limit  <= cfg_wdata[FAIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_req;
            slot_reg <= s_slot;
        end
        if (st_fire) begin
            m_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st_vld_reg <= 1'b1;
            end else if (st_fire) begin
                st_vld_reg <= 1'b0;
            end
            if (st_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    pspcr_slot_store #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_slot (s_slot),
        .wr_en   (st_fire),
        .wr_slot (slot_reg),
        .wr_data (nxt_state),
        .rd_data (cur_state)
    );

    pspcr_step u_step (
        .req (req_reg),
        .cur (cur_state),
        .cfg (cfg_reg),
        .nxt (nxt_state),
        .res (res)
    );

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st_vld_reg)
        else $error("accepted item did not reach the request stage");

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !st_vld_reg |-> s_tready)
        else $error("input stalled with an empty request stage");

    a_one_bus_op: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_res_reg.did_config_write && m_res_reg.did_bus_read))
        else $error("result reports both a config write and a register read");

    a_no_value_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_res_reg.did_config_write |-> !m_res_reg.value_ok)
        else $error("value returned on a configuration write item");

    a_fire_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        st_fire |=> m_tvalid_reg)
        else $error("processed item did not reach the output register");

endmodule

### hw/rtl/pspcr_slot_store.sv
module pspcr_slot_store
    import pspcr_pkg::*;
#(
    parameter int SLOTS  = 8,
    parameter int SLOT_W = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_slot,
    input  slot_state_t       wr_data,
    output slot_state_t       rd_data
);

    slot_state_t       state_mem [SLOTS];
    slot_state_t       mem_q_reg;
    slot_state_t       byp_data_reg;
    logic              byp_hit_reg;
    logic              touched_q_reg;
    logic [SLOTS-1:0]  touched_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            state_mem[wr_slot] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg    <= state_mem[rd_slot];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touched_reg   <= '0;
            touched_q_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                touched_reg[wr_slot] <= 1'b1;
            end
            if (rd_en) begin
                touched_q_reg <= touched_reg[rd_slot];
                byp_hit_reg   <= wr_en && (wr_slot == rd_slot);
            end
        end
    end

    // A write in the same cycle as the read to the same slot is forwarded.
    always_comb begin
        if (byp_hit_reg) begin
            rd_data = byp_data_reg;
        end else if (!touched_q_reg) begin
            rd_data = SLOT_RESET;
        end else begin
            rd_data = mem_q_reg;
        end
    end

endmodule

### hw/rtl/pspcr_step.sv
module pspcr_step
    import pspcr_pkg::*;
(
    input  req_t        req,
    input  slot_state_t cur,
    input  cfg_t        cfg,
    output slot_state_t nxt,
    output result_t     res
);

    logic [NOW_W-1:0]        retry_age;
    logic [NOW_W-1:0]        cache_age;
    logic                    refresh_due;
    logic [FAIL_W-1:0]       fail_inc;
    logic [VOLT_W-1:0]       new_volt;
    logic [VOLT_W-1:0]       use_volt;
    logic signed [RAW_W-1:0] use_shunt;
    logic signed [NOW_W-1:0] product;
    logic                    fresh;

    assign retry_age   = req.now_ms - cur.last_good_ms;
    assign cache_age   = req.now_ms - cur.cache_time_ms;
    assign refresh_due = !cur.cache_valid || (cache_age > NOW_W'(cfg.cache_age_ms));
    assign fail_inc    = (cur.fail_count < FAIL_SAT) ? cur.fail_count + 3'd1 : FAIL_SAT;
    assign new_volt    = {req.raw_bus_word[RAW_W-1:3], 2'b00};
    assign fresh       = !refresh_due || req.bus_read_ok;

    always_comb begin
        if (refresh_due) begin
            use_volt  = new_volt;
            use_shunt = signed'(req.raw_shunt_word);
        end else begin
            use_volt  = cur.volt_mv;
            use_shunt = cur.shunt;
        end
    end

    assign product = signed'({1'b0, use_volt}) * use_shunt;

    always_comb begin
        nxt = cur;
        res = '0;
        case (cur.mode)
            MODE_ERROR: begin
                if (retry_age > NOW_W'(cfg.retry_ms)) begin
                    nxt.mode       = MODE_UNINIT;
                    nxt.fail_count = '0;
                end
            end
            MODE_UNINIT: begin
                res.did_config_write = 1'b1;
                res.config_word = (req.range_option == OPT_RANGE_32V)
                                ? CONF_WORD_32V : CONF_WORD_16V;
                if (req.init_write_ok) begin
                    nxt.mode       = MODE_READY;
                    nxt.fail_count = '0;
                end else begin
                    nxt.mode       = MODE_ERROR;
                    nxt.fail_count = 3'd1;
                end
            end
            MODE_READY: begin
                if (refresh_due) begin
                    res.did_bus_read = 1'b1;
                    if (req.bus_read_ok) begin
                        nxt.volt_mv       = new_volt;
                        nxt.shunt         = signed'(req.raw_shunt_word);
                        nxt.cache_valid   = 1'b1;
                        nxt.cache_time_ms = req.now_ms;
                        nxt.last_good_ms  = req.now_ms;
                        nxt.fail_count    = '0;
                    end else begin
                        nxt.fail_count = fail_inc;
                        if (fail_inc >= cfg.error_limit) begin
                            nxt.mode = MODE_ERROR;
                        end
                    end
                end
                if (fresh) begin
                    case (req.channel)
                        CHAN_VOLT: begin
                            res.value_ok = 1'b1;
                            res.reading  = signed'(READING_W'(use_volt));
                        end
                        CHAN_CURRENT: begin
                            res.value_ok = 1'b1;
                            res.reading  = READING_W'(use_shunt);
                        end
                        CHAN_POWER: begin
                            res.value_ok = 1'b1;
                            res.reading  = product[READING_W-1:0];
                        end
                        default: begin
                            res.value_ok = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule
